[rtl/yrgb_pkg.sv]
// ---------------------------------------------------------------------------
// yrgb_pkg
// Shared types and constants of the YUV to RGB decoder with hue and
// saturation control: pixel payloads, register indexes, stage enables.
// ---------------------------------------------------------------------------
`default_nettype none

package yrgb_pkg;

   // sample format: signed, 1.0 = 2^(SAMPLE_BITS-2)
   localparam int SAMPLE_BITS = 16;

   // rotated chroma and luma inside the matrix lanes keep full precision
   localparam int CHROMA_BITS = SAMPLE_BITS + 6;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ROW_RED     = 3'd0,
      REG_ROW_GREEN   = 3'd1,
      REG_ROW_BLUE    = 3'd2,
      REG_CHROMA_COS  = 3'd3,
      REG_CHROMA_SIN  = 3'd4,
      REG_OUT_OFFSET  = 3'd5,
      REG_OUT_GAIN    = 3'd6
   } yrgb_reg_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] luma;
      logic signed [SAMPLE_BITS-1:0] chroma_u;
      logic signed [SAMPLE_BITS-1:0] chroma_v;
   } yrgb_pixel_in_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] red;
      logic signed [SAMPLE_BITS-1:0] green;
      logic signed [SAMPLE_BITS-1:0] blue;
   } yrgb_pixel_out_type;

   // load enables of the stages that live inside a color lane
   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } yrgb_lane_en_type;

endpackage

`default_nettype wire

[rtl/yrgb_color_lane.sv]
// ---------------------------------------------------------------------------
// yrgb_color_lane
// One output color: matrix row times (Y, U', V'), rounding, gain, rounding,
// offset and saturation, in four register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module yrgb_color_lane #(
   parameter int COEFF_BITS = 18
) (
   input  wire logic                                     clock,
   input  wire yrgb_pkg::yrgb_lane_en_type               en,
   input  wire logic [3*COEFF_BITS-1:0]                  row_coeffs,
   input  wire logic signed [COEFF_BITS-1:0]             gain,
   input  wire logic signed [yrgb_pkg::SAMPLE_BITS-1:0]  offset,
   input  wire logic signed [yrgb_pkg::CHROMA_BITS-1:0]  y_val,
   input  wire logic signed [yrgb_pkg::CHROMA_BITS-1:0]  u_val,
   input  wire logic signed [yrgb_pkg::CHROMA_BITS-1:0]  v_val,
   output logic signed [yrgb_pkg::SAMPLE_BITS-1:0]       sample
);
   import yrgb_pkg::*;

   localparam int CF    = COEFF_BITS - 4;
   localparam int PW    = COEFF_BITS + CHROMA_BITS;
   localparam int ACCW  = PW + 2;
   localparam int RAWW  = ACCW - CF;
   localparam int GPW   = RAWW + COEFF_BITS;
   localparam int GSW   = GPW + 1;
   localparam int OW    = GSW - CF + 1;

   localparam logic signed [ACCW-1:0] HALF_ACC = ACCW'(1) <<< (CF - 1);
   localparam logic signed [GSW-1:0]  HALF_G   = GSW'(1) <<< (CF - 1);
   localparam logic signed [OW-1:0]   SAT_MAX  = OW'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [OW-1:0]   SAT_MIN  = -SAT_MAX - OW'(1);

   logic signed [COEFF_BITS-1:0] coef_y, coef_u, coef_v;

   logic signed [PW-1:0]          prod_y_ff, prod_u_ff, prod_v_ff;
   logic signed [PW-1:0]          prod_y_in, prod_u_in, prod_v_in;
   logic signed [ACCW-1:0]        acc;
   logic signed [RAWW-1:0]        raw_ff, raw_in;
   logic signed [GPW-1:0]         gprod_ff, gprod_in;
   logic signed [GSW-1:0]         gsum;
   logic signed [OW-1:0]          biased;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;

   assign coef_y = $signed(row_coeffs[0 +: COEFF_BITS]);
   assign coef_u = $signed(row_coeffs[COEFF_BITS +: COEFF_BITS]);
   assign coef_v = $signed(row_coeffs[2*COEFF_BITS +: COEFF_BITS]);

   always_comb begin
      prod_y_in = PW'(coef_y * y_val);
      prod_u_in = PW'(coef_u * u_val);
      prod_v_in = PW'(coef_v * v_val);

      // round half up, floor shift
      acc    = ACCW'(prod_y_ff) + ACCW'(prod_u_ff) + ACCW'(prod_v_ff) + HALF_ACC;
      raw_in = RAWW'(acc >>> CF);

      gprod_in = GPW'(raw_ff * gain);

      gsum   = GSW'(gprod_ff) + HALF_G;
      biased = OW'(gsum >>> CF) + OW'(offset);
      if (biased > SAT_MAX) begin
         sample_in = SAMPLE_BITS'(SAT_MAX);
      end else if (biased < SAT_MIN) begin
         sample_in = SAMPLE_BITS'(SAT_MIN);
      end else begin
         sample_in = SAMPLE_BITS'(biased);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         prod_y_ff <= prod_y_in;
         prod_u_ff <= prod_u_in;
         prod_v_ff <= prod_v_in;
      end
      if (en.s4) begin
         raw_ff <= raw_in;
      end
      if (en.s5) begin
         gprod_ff <= gprod_in;
      end
      if (en.s6) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

`default_nettype wire

[rtl/yuv_to_rgb_hue_sat_decoder.sv]
// ---------------------------------------------------------------------------
// yuv_to_rgb_hue_sat_decoder
// Y,U,V to R,G,B pixel converter with hue rotation, saturation, 3x3 matrix,
// gain, offset and output saturation.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel carries one Y,U,V pixel per item, rsp_ channel one R,G,B
//   pixel per item, both valid/ready. Every input item gives one result.
//   csr_ port writes a register when csr_we is high; index past the list
//   is ignored. Write registers only while no item is in flight.
// Pipeline:
//   six register stages: chroma products, rotated chroma, matrix products,
//   matrix sum, gain product, offset and saturation. One item per cycle
//   sustained while rsp_ready stays high.
// Reset:
//   synchronous; empties the pipeline and loads identity matrix, unit
//   cos*saturation, zero sin, zero offset and unit gain.
// Stall:
//   each stage loads when it is empty or its successor loads, so bubbles
//   are squeezed out; req_ready drops only once all six stages hold an
//   item and rsp_ready is low.
// ---------------------------------------------------------------------------
`default_nettype none

module yuv_to_rgb_hue_sat_decoder #(
   parameter int COEFF_BITS = 18
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire yrgb_pkg::yrgb_pixel_in_type       req_pixel,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output yrgb_pkg::yrgb_pixel_out_type           rsp_pixel,
   input  wire logic                              csr_we,
   input  wire logic [yrgb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [3*COEFF_BITS-1:0]           csr_wdata
);
   import yrgb_pkg::*;

   localparam int STAGES = 6;
   localparam int CF     = COEFF_BITS - 4;
   localparam int ROW_W  = 3 * COEFF_BITS;
   localparam int P1W    = SAMPLE_BITS + COEFF_BITS;
   localparam int SUM1W  = P1W + 2;

   localparam logic [ROW_W-1:0]       ONE_ROW = ROW_W'(1) << CF;
   localparam logic [COEFF_BITS-1:0]  ONE_C   = COEFF_BITS'(1) << CF;
   localparam logic signed [SUM1W-1:0] HALF1  = SUM1W'(1) <<< (CF - 1);

   // configuration
   logic [ROW_W-1:0]              row_red_ff, row_green_ff, row_blue_ff;
   logic signed [COEFF_BITS-1:0]  cos_ff, sin_ff, gain_ff;
   logic signed [SAMPLE_BITS-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_red_ff   <= ONE_ROW;
         row_green_ff <= ONE_ROW << COEFF_BITS;
         row_blue_ff  <= ONE_ROW << (2 * COEFF_BITS);
         cos_ff       <= ONE_C;
         sin_ff       <= '0;
         offset_ff    <= '0;
         gain_ff      <= ONE_C;
      end else if (csr_we) begin
         unique case (yrgb_reg_index_type'(csr_index))
            REG_ROW_RED:    row_red_ff   <= csr_wdata;
            REG_ROW_GREEN:  row_green_ff <= csr_wdata;
            REG_ROW_BLUE:   row_blue_ff  <= csr_wdata;
            REG_CHROMA_COS: cos_ff       <= csr_wdata[COEFF_BITS-1:0];
            REG_CHROMA_SIN: sin_ff       <= csr_wdata[COEFF_BITS-1:0];
            REG_OUT_OFFSET: offset_ff    <= csr_wdata[SAMPLE_BITS-1:0];
            REG_OUT_GAIN:   gain_ff      <= csr_wdata[COEFF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [STAGES-1:0] valid_ff, valid_in, en;
   yrgb_lane_en_type  lane_en;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
      lane_en.s3 = en[2];
      lane_en.s4 = en[3];
      lane_en.s5 = en[4];
      lane_en.s6 = en[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // stage 1: chroma rotation products
   logic signed [P1W-1:0]         cu_ff, sv_ff, cv_ff, su_ff;
   logic signed [P1W-1:0]         cu_in, sv_in, cv_in, su_in;
   logic signed [SAMPLE_BITS-1:0] y1_ff;

   // stage 2: rotated chroma
   logic signed [SUM1W-1:0]       u_sum, v_sum;
   logic signed [CHROMA_BITS-1:0] ur_ff, vr_ff, y2_ff, ur_in, vr_in;

   always_comb begin
      cu_in = P1W'(cos_ff * req_pixel.chroma_u);
      sv_in = P1W'(sin_ff * req_pixel.chroma_v);
      cv_in = P1W'(cos_ff * req_pixel.chroma_v);
      su_in = P1W'(sin_ff * req_pixel.chroma_u);

      u_sum = SUM1W'(cu_ff) + SUM1W'(sv_ff) + HALF1;
      v_sum = SUM1W'(cv_ff) - SUM1W'(su_ff) + HALF1;
      ur_in = CHROMA_BITS'(u_sum >>> CF);
      vr_in = CHROMA_BITS'(v_sum >>> CF);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cu_ff <= cu_in;
         sv_ff <= sv_in;
         cv_ff <= cv_in;
         su_ff <= su_in;
         y1_ff <= req_pixel.luma;
      end
      if (en[1]) begin
         ur_ff <= ur_in;
         vr_ff <= vr_in;
         y2_ff <= CHROMA_BITS'(y1_ff);
      end
   end

   // stages 3 to 6: one lane per color
   yrgb_color_lane #(.COEFF_BITS(COEFF_BITS)) u_red (
      .clock      (clock),
      .en         (lane_en),
      .row_coeffs (row_red_ff),
      .gain       (gain_ff),
      .offset     (offset_ff),
      .y_val      (y2_ff),
      .u_val      (ur_ff),
      .v_val      (vr_ff),
      .sample     (rsp_pixel.red)
   );

   yrgb_color_lane #(.COEFF_BITS(COEFF_BITS)) u_green (
      .clock      (clock),
      .en         (lane_en),
      .row_coeffs (row_green_ff),
      .gain       (gain_ff),
      .offset     (offset_ff),
      .y_val      (y2_ff),
      .u_val      (ur_ff),
      .v_val      (vr_ff),
      .sample     (rsp_pixel.green)
   );

   yrgb_color_lane #(.COEFF_BITS(COEFF_BITS)) u_blue (
      .clock      (clock),
      .en         (lane_en),
      .row_coeffs (row_blue_ff),
      .gain       (gain_ff),
      .offset     (offset_ff),
      .y_val      (y2_ff),
      .u_val      (ur_ff),
      .v_val      (vr_ff),
      .sample     (rsp_pixel.blue)
   );

`ifndef SYNTHESIS
   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // input is only held off when every stage is occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input stalled with a bubble in the pipeline");

   // a stage whose successor does not load keeps its item
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !en[3]) |=> valid_ff[2])
      else $error("item dropped in matrix stage");

   // an item entering an empty pipeline with no stall reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && valid_ff == '0 && rsp_ready) ##1 rsp_ready ##1 rsp_ready
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("item lost in pipeline");
`endif

endmodule

`default_nettype wire

[tb/yrgb_pixel_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// yrgb_pixel_checker
// Watches the pixel, result and register ports of the YUV to RGB decoder.
// Keeps its own copy of the registers, works out the R,G,B pixel for every
// accepted Y,U,V item and compares it, in order, with each accepted result.
// ---------------------------------------------------------------------------
module yrgb_pixel_checker #(
   parameter int COEFF_BITS = 18
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  yrgb_pkg::yrgb_pixel_in_type             req_pixel,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  yrgb_pkg::yrgb_pixel_out_type            rsp_pixel,
   input  logic                                    csr_we,
   input  logic [yrgb_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [3*COEFF_BITS-1:0]                 csr_wdata,
   output int                                      failures
);
   import yrgb_pkg::*;

   localparam int FRAC = COEFF_BITS - 4;
   localparam int ROW_BITS = 3 * COEFF_BITS;
   localparam logic [ROW_BITS-1:0] ROW_UNIT = ROW_BITS'(1) << FRAC;
   localparam logic signed [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(1) << FRAC;

   logic [ROW_BITS-1:0]           red_row;
   logic [ROW_BITS-1:0]           green_row;
   logic [ROW_BITS-1:0]           blue_row;
   logic signed [COEFF_BITS-1:0]  hue_cos;
   logic signed [COEFF_BITS-1:0]  hue_sin;
   logic signed [COEFF_BITS-1:0]  out_gain;
   logic signed [SAMPLE_BITS-1:0] out_offset;

   yrgb_pixel_out_type rgb_expected[$];
   yrgb_pixel_out_type rgb_want;
   int mismatch_count = 0;
   int pending = 0;

   // anything still queued at the end counts against the run
   assign failures = mismatch_count + pending;

   // round half up, floor for negative values
   function automatic longint round_frac(input longint x);
      return (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(input longint x);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
         x = hi;
      end else if (x < lo) begin
         x = lo;
      end
      return x[SAMPLE_BITS-1:0];
   endfunction

   function automatic longint row_coeff(input logic [ROW_BITS-1:0] row, input int k);
      logic signed [COEFF_BITS-1:0] c;
      c = row[k*COEFF_BITS +: COEFF_BITS];
      return longint'(c);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] mix_color(
      input logic [ROW_BITS-1:0] row, input longint y, input longint u, input longint v);
      longint raw;
      raw = round_frac(row_coeff(row, 0) * y + row_coeff(row, 1) * u + row_coeff(row, 2) * v);
      return clip_sample(round_frac(raw * longint'(out_gain)) + longint'(out_offset));
   endfunction

   function automatic yrgb_pixel_out_type convert_pixel(input yrgb_pixel_in_type p);
      yrgb_pixel_out_type rgb;
      longint y;
      longint u;
      longint v;
      longint c;
      longint s;
      longint u_rot;
      longint v_rot;
      y = longint'($signed(p.luma));
      u = longint'($signed(p.chroma_u));
      v = longint'($signed(p.chroma_v));
      c = longint'(hue_cos);
      s = longint'(hue_sin);
      // hue rotation and saturation on the chroma pair
      u_rot = round_frac(c * u + s * v);
      v_rot = round_frac(c * v - s * u);
      rgb.red   = mix_color(red_row, y, u_rot, v_rot);
      rgb.green = mix_color(green_row, y, u_rot, v_rot);
      rgb.blue  = mix_color(blue_row, y, u_rot, v_rot);
      return rgb;
   endfunction

   task automatic check_field(input string name, input logic signed [SAMPLE_BITS-1:0] want,
                              input logic signed [SAMPLE_BITS-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         red_row    <= ROW_UNIT;
         green_row  <= ROW_UNIT << COEFF_BITS;
         blue_row   <= ROW_UNIT << (2 * COEFF_BITS);
         hue_cos    <= COEFF_ONE;
         hue_sin    <= '0;
         out_offset <= '0;
         out_gain   <= COEFF_ONE;
         rgb_expected.delete();
         pending    <= 0;
      end else begin
         if (req_valid && req_ready) begin
            rgb_expected.push_back(convert_pixel(req_pixel));
         end
         if (rsp_valid && rsp_ready) begin
            if (rgb_expected.size() == 0) begin
               mismatch_count++;
               $error("pixel: no item waiting for result %h", rsp_pixel);
            end else begin
               rgb_want = rgb_expected.pop_front();
               check_field("red", rgb_want.red, rsp_pixel.red);
               check_field("green", rgb_want.green, rsp_pixel.green);
               check_field("blue", rgb_want.blue, rsp_pixel.blue);
            end
         end
         if (csr_we) begin
            case (yrgb_reg_index_type'(csr_index))
               REG_ROW_RED: begin
                  red_row <= csr_wdata;
               end
               REG_ROW_GREEN: begin
                  green_row <= csr_wdata;
               end
               REG_ROW_BLUE: begin
                  blue_row <= csr_wdata;
               end
               REG_CHROMA_COS: begin
                  hue_cos <= csr_wdata[COEFF_BITS-1:0];
               end
               REG_CHROMA_SIN: begin
                  hue_sin <= csr_wdata[COEFF_BITS-1:0];
               end
               REG_OUT_OFFSET: begin
                  out_offset <= csr_wdata[SAMPLE_BITS-1:0];
               end
               REG_OUT_GAIN: begin
                  out_gain <= csr_wdata[COEFF_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         pending <= rgb_expected.size();
      end
   end

endmodule

[tb/yuv_to_rgb_hue_sat_decoder_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// yuv_to_rgb_hue_sat_decoder_tb
// Drives Y,U,V pixels through the decoder under a series of register
// settings (reset identity, extremes, a BT.601 matrix, random) and with
// random idling on both channels; the pixel checker predicts and compares.
// ---------------------------------------------------------------------------
module yuv_to_rgb_hue_sat_decoder_tb;
   import yrgb_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int COEFF_BITS = 18;
   localparam int ROW_BITS = 3 * COEFF_BITS;
   localparam int COEFF_ONE = 16384;
   localparam int COEFF_MAX = 131071;
   localparam int COEFF_MIN = -131072;
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_UNUSED = 3'd7;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 125;
   localparam int HOLD_CYCLES = 40;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT = 400000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   yrgb_pixel_in_type         req_pixel = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   yrgb_pixel_out_type        rsp_pixel;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ROW_BITS-1:0]       csr_wdata = '0;

   idle_mode_type idle_mode = IDLE_NONE;
   bit  hold_req = 1'b0;
   int  hold_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  cycle_count = 0;
   int  failures;

   yuv_to_rgb_hue_sat_decoder #(
      .COEFF_BITS(COEFF_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel(rsp_pixel),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   yrgb_pixel_checker #(
      .COEFF_BITS(COEFF_BITS)
   ) pixel_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel(rsp_pixel),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .failures(failures)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
      end
   end

   // result side: one long hold-off to fill the pipeline, else random stalls or always ready
   always @(posedge clock) begin
      if (hold_req && hold_count < HOLD_CYCLES) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: begin
               rsp_ready <= ($urandom_range(99) >= 57);
            end
            IDLE_BOTH: begin
               rsp_ready <= ($urandom_range(99) >= 7);
            end
            default: begin
               rsp_ready <= 1'b1;
            end
         endcase
      end
   end

   function automatic logic [ROW_BITS-1:0] pack_row(input int c0, input int c1, input int c2);
      return {COEFF_BITS'(c2), COEFF_BITS'(c1), COEFF_BITS'(c0)};
   endfunction

   function automatic int rand_sample();
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   // narrow coefficients stay within +-2.0 so most results do not clip
   function automatic int rand_coeff(input bit wide);
      if (wide) begin
         return int'($urandom_range(2 * COEFF_MAX + 1)) + COEFF_MIN;
      end
      return int'($urandom_range(4 * COEFF_ONE)) - 2 * COEFF_ONE;
   endfunction

   // called at a rising edge, holds req_valid low while idle
   task automatic idle_gap();
      int pct;
      pct = (idle_mode == IDLE_SENDER) ? 57 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      if (pct > 0 && $urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < pct);
      end
   endtask

   task automatic send_yuv(input int y, input int u, input int v);
      idle_gap();
      req_valid          <= 1'b1;
      req_pixel.luma     <= SAMPLE_BITS'(y);
      req_pixel.chroma_u <= SAMPLE_BITS'(u);
      req_pixel.chroma_v <= SAMPLE_BITS'(v);
      @(negedge clock);
      while (!req_ready) begin
         @(negedge clock);
      end
      @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (results_seen != items_sent) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input logic [ROW_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // junk goes above the narrow fields and to the unused index
   task automatic program_regs(input logic [ROW_BITS-1:0] red_row,
                               input logic [ROW_BITS-1:0] green_row,
                               input logic [ROW_BITS-1:0] blue_row,
                               input int hue_cos, input int hue_sin,
                               input int out_offset, input int out_gain);
      csr_write(CSR_INDEX_UNUSED, ROW_BITS'({$urandom, $urandom}));
      csr_write(REG_ROW_RED, red_row);
      csr_write(REG_ROW_GREEN, green_row);
      csr_write(REG_ROW_BLUE, blue_row);
      csr_write(REG_CHROMA_COS, {36'({$urandom, $urandom}), COEFF_BITS'(hue_cos)});
      csr_write(REG_CHROMA_SIN, {36'({$urandom, $urandom}), COEFF_BITS'(hue_sin)});
      csr_write(REG_OUT_OFFSET, {38'({$urandom, $urandom}), SAMPLE_BITS'(out_offset)});
      csr_write(REG_OUT_GAIN, {36'({$urandom, $urandom}), COEFF_BITS'(out_gain)});
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [ROW_BITS-1:0] bt601_red;
      logic [ROW_BITS-1:0] bt601_green;
      logic [ROW_BITS-1:0] bt601_blue;
      bit wide;

      bt601_red   = pack_row(COEFF_ONE, 0, 22970);
      bt601_green = pack_row(COEFF_ONE, -5638, -11700);
      bt601_blue  = pack_row(COEFF_ONE, 29032, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // registers as left by reset
      send_yuv(0, 0, 0);
      send_yuv(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      send_yuv(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      send_yuv(SAMPLE_MAX, SAMPLE_MIN, 0);
      send_yuv(SAMPLE_MIN, SAMPLE_MAX, -1);
      send_yuv(-1, -1, -1);
      send_yuv(1, -1, 1);
      send_yuv(COEFF_ONE, -COEFF_ONE, COEFF_ONE);
      send_yuv(21845, -21846, 21845);
      send_yuv(-21846, 21845, -21846);
      drain();

      // extreme coefficients, clipping on both sides
      program_regs(pack_row(COEFF_ONE, COEFF_ONE, COEFF_ONE),
                   pack_row(COEFF_MAX, COEFF_MIN, COEFF_MAX),
                   pack_row(COEFF_MIN, COEFF_MIN, COEFF_MIN),
                   COEFF_MAX, COEFF_MIN, SAMPLE_MIN, COEFF_MAX);
      send_yuv(0, 0, 0);
      send_yuv(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      send_yuv(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      send_yuv(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
      send_yuv(1, 1, -1);
      send_yuv(-1, 0, 1);
      drain();

      // quarter-turn hue, most negative gain, top offset
      program_regs(pack_row(COEFF_ONE, 0, 0), pack_row(0, COEFF_ONE, 0),
                   pack_row(0, 0, COEFF_ONE), 0, COEFF_ONE, SAMPLE_MAX, COEFF_MIN);
      send_yuv(0, 0, 0);
      send_yuv(SAMPLE_MAX, 0, SAMPLE_MIN);
      send_yuv(SAMPLE_MIN, SAMPLE_MAX, 0);
      send_yuv(1, 1, 1);
      send_yuv(-1, -1, -1);
      send_yuv(8192, -8192, 4096);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         wide = (phase == PHASES - 1);
         case (phase)
            0: program_regs(bt601_red, bt601_green, bt601_blue, COEFF_ONE, 0, 0, COEFF_ONE);
            1: program_regs(bt601_red, bt601_green, bt601_blue, rand_coeff(1'b0),
                            rand_coeff(1'b0), rand_sample(), rand_coeff(1'b0));
            2: program_regs(pack_row(COEFF_MAX, COEFF_MAX, COEFF_MAX),
                            pack_row(COEFF_MAX, COEFF_MAX, COEFF_MAX),
                            pack_row(COEFF_MAX, COEFF_MAX, COEFF_MAX),
                            COEFF_MAX, COEFF_MAX, SAMPLE_MAX, COEFF_MAX);
            3: program_regs(pack_row(COEFF_MIN, COEFF_MIN, COEFF_MIN),
                            pack_row(COEFF_MIN, COEFF_MIN, COEFF_MIN),
                            pack_row(COEFF_MIN, COEFF_MIN, COEFF_MIN),
                            COEFF_MIN, COEFF_MIN, SAMPLE_MIN, COEFF_MIN);
            default: program_regs(
                  pack_row(rand_coeff(wide), rand_coeff(wide), rand_coeff(wide)),
                  pack_row(rand_coeff(wide), rand_coeff(wide), rand_coeff(wide)),
                  pack_row(rand_coeff(wide), rand_coeff(wide), rand_coeff(wide)),
                  rand_coeff(wide), rand_coeff(wide),
                  int'($signed(16'($urandom))), rand_coeff(wide));
         endcase
         idle_mode = idle_mode_type'(phase % 4);
         // first phase runs flat out against a stalled result side
         if (phase == 0) begin
            hold_req = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_yuv(rand_sample(), rand_sample(), rand_sample());
         end
         drain();
      end

      idle_mode = IDLE_NONE;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[yuv_to_rgb_hue_sat_decoder.f]
rtl/yrgb_pkg.sv
rtl/yrgb_color_lane.sv
rtl/yuv_to_rgb_hue_sat_decoder.sv
tb/yrgb_pixel_checker.sv
tb/yuv_to_rgb_hue_sat_decoder_tb.sv
